// ===== src/ppf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppf_pkg: shared types and constants of the printer preamble framer
// Field widths, frame byte constants and configuration register indexes.
// ----------------------------------------------------------------------------
package ppf_pkg;

  // Payload widths
  localparam int unsigned CountW   = 12;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LenW     = 5;

  // Fixed frame bytes and marker bits
  localparam logic [ByteW-1:0] CmdByte  = 8'h14;
  localparam logic [ByteW-1:0] TermByte = 8'h02;
  localparam logic [1:0]       HiMark   = 2'b11;  // 0xC0 group
  localparam logic [1:0]       LoMark   = 2'b10;  // 0x80 group

  // Bytes before the checksum when every count fits one byte, no size number
  localparam logic [LenW-1:0]  BaseLen  = 5'd17;

  // Configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_LINK_MODE    = 3'd0,
    REG_DOT_MODE     = 3'd1,
    REG_RECT_CODE    = 3'd2,
    REG_MODE_FIRST   = 3'd3,
    REG_MODE_SECOND  = 3'd4,
    REG_PRINTER_TYPE = 3'd5
  } cfg_reg_e;

endpackage

// ===== src/ppf_if.sv =====
// ----------------------------------------------------------------------------
// ppf interfaces: request, frame byte and configuration channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface ppf_req_if;
  logic                        valid;
  logic                        ready;
  logic [ppf_pkg::CountW-1:0]  pixels_per_line;
  logic [ppf_pkg::CountW-1:0]  line_count;
  logic [ppf_pkg::CountW-1:0]  copy_count;
  logic [ppf_pkg::CountW-1:0]  size_number;

  modport source (output valid, pixels_per_line, line_count, copy_count, size_number,
                  input ready);
  modport sink   (input valid, pixels_per_line, line_count, copy_count, size_number,
                  output ready);
endinterface

interface ppf_frame_if;
  logic                       valid;
  logic                       ready;
  logic [ppf_pkg::ByteW-1:0]  frame_byte;
  logic                       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface ppf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ppf_pkg::RegIdxW-1:0]   reg_index;
  logic [ppf_pkg::CfgDataW-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== src/printer_preamble_framer.sv =====
// ----------------------------------------------------------------------------
// printer_preamble_framer: turns one print request into a preamble byte frame
//
// req_i carries one request (pixels per line, line count, copy count, size
// number). frm_o returns the frame one byte per transaction, with last_byte
// set on the terminator. cfg_i writes the six mode registers; it is always
// ready, and the user must write it only while no frame is in flight; the
// block itself does not enforce this. A request lands in a one-entry input
// register; the byte sequencer loads it and emits 19 to 24 bytes, one per
// cycle while frm_o does not stall, into an output register. The first byte
// passes from the input register through the sequencer into the output
// register. The input register takes the next request while a frame is
// still going out, and the sequencer loads it on the terminator cycle, so
// frames follow with no gap. The checksum is accumulated as bytes leave the
// sequencer. Reset clears the configuration registers to zero and drops any
// request. When frm_o stalls, the output register holds its byte and the
// sequencer waits; req_i is held off once the input register is full.
// ----------------------------------------------------------------------------
module printer_preamble_framer (
  input  logic           clk_i,
  input  logic           rst_ni,
  ppf_req_if.sink        req_i,
  ppf_cfg_if.sink        cfg_i,
  ppf_frame_if.source    frm_o
);

  typedef enum logic [4:0] {
    S_CMD, S_LEN, S_PPL, S_LINES, S_COMM, S_COPIES, S_PSM, S_SIZE,
    S_MB0, S_MB1, S_MB2, S_MB3, S_MB4, S_MB5, S_MB6, S_MB7,
    S_PT_HI, S_PT_LO, S_SUM, S_TERM
  } slot_e;

  // Configuration registers
  logic [ppf_pkg::ByteW-1:0]    link_mode_q, dot_mode_q, rect_code_q;
  logic [ppf_pkg::CfgDataW-1:0] mode_first_q, mode_second_q;
  logic [15:0]                  printer_type_q;

  // Input register
  logic                         pend_q;
  logic [ppf_pkg::CountW-1:0]   p_ppl_q, p_lines_q, p_copies_q, p_size_q;

  // Sequencer
  logic                         busy_q, busy_d;
  slot_e                        slot_q, slot_d;
  logic                         lo_q, lo_d;
  logic [6:0]                   sum_q, sum_d;
  logic [ppf_pkg::LenW-1:0]     len_q;
  logic [ppf_pkg::CountW-1:0]   e_ppl_q, e_lines_q, e_copies_q, e_size_q;

  // Output register
  logic                         out_vld_q;
  logic [ppf_pkg::ByteW-1:0]    out_byte_q;
  logic                         out_last_q;

  logic                         adv, load, size_on;
  logic [ppf_pkg::ByteW-1:0]    cur_byte;
  logic [ppf_pkg::CountW-1:0]   cur_count;
  logic                         cur_is_count, cur_two;
  logic [ppf_pkg::LenW-1:0]     load_len;

  function automatic logic is_big(input logic [ppf_pkg::CountW-1:0] v);
    return (v[ppf_pkg::CountW-1:6] != '0);
  endfunction

  // Encode a count byte; mark picks 0xC0 or 0x80 for the first byte only
  function automatic logic [ppf_pkg::ByteW-1:0] count_byte(
    input logic [ppf_pkg::CountW-1:0] v,
    input logic                       lo,
    input logic [1:0]                 mark
  );
    logic [ppf_pkg::ByteW-1:0] b;
    if (is_big(v) && !lo) begin
      b = {mark, v[ppf_pkg::CountW-1:6]};
    end else if (is_big(v)) begin
      b = {ppf_pkg::LoMark, v[5:0]};
    end else begin
      b = {mark, v[5:0]};
    end
    return b;
  endfunction

  // Handshakes
  assign size_on      = (dot_mode_q == rect_code_q);
  assign adv          = busy_q && (!out_vld_q || frm_o.ready);
  assign load         = pend_q && (!busy_q || (adv && (slot_q == S_TERM)));
  assign req_i.ready  = !pend_q;
  assign cfg_i.ready  = 1'b1;
  assign frm_o.valid      = out_vld_q;
  assign frm_o.frame_byte = out_byte_q;
  assign frm_o.last_byte  = out_last_q;

  // Byte count before the checksum for the request being loaded
  always_comb begin
    load_len = ppf_pkg::BaseLen
             + ppf_pkg::LenW'(is_big(p_ppl_q))
             + ppf_pkg::LenW'(is_big(p_lines_q))
             + ppf_pkg::LenW'(is_big(p_copies_q));
    if (size_on) begin
      load_len = load_len + ppf_pkg::LenW'(1) + ppf_pkg::LenW'(is_big(p_size_q));
    end
  end

  // Select the count of the current slot
  always_comb begin
    cur_is_count = 1'b1;
    case (slot_q)
      S_PPL:    cur_count = e_ppl_q;
      S_LINES:  cur_count = e_lines_q;
      S_COPIES: cur_count = e_copies_q;
      S_SIZE:   cur_count = e_size_q;
      default: begin
        cur_count    = '0;
        cur_is_count = 1'b0;
      end
    endcase
  end
  assign cur_two = cur_is_count && is_big(cur_count) && !lo_q;

  // Current frame byte
  always_comb begin
    case (slot_q)
      S_CMD:   cur_byte = ppf_pkg::CmdByte;
      S_LEN:   cur_byte = {ppf_pkg::HiMark, 1'b0, len_q};
      S_PPL, S_LINES, S_COPIES:
               cur_byte = count_byte(cur_count, lo_q, ppf_pkg::HiMark);
      S_SIZE:  cur_byte = count_byte(cur_count, lo_q, ppf_pkg::LoMark);
      S_COMM:  cur_byte = link_mode_q;
      S_PSM:   cur_byte = dot_mode_q;
      S_MB0:   cur_byte = mode_first_q[31:24];
      S_MB1:   cur_byte = mode_first_q[23:16];
      S_MB2:   cur_byte = mode_first_q[15:8];
      S_MB3:   cur_byte = mode_first_q[7:0];
      S_MB4:   cur_byte = mode_second_q[31:24];
      S_MB5:   cur_byte = mode_second_q[23:16];
      S_MB6:   cur_byte = mode_second_q[15:8];
      S_MB7:   cur_byte = mode_second_q[7:0];
      S_PT_HI: cur_byte = printer_type_q[15:8];
      S_PT_LO: cur_byte = printer_type_q[7:0];
      S_SUM:   cur_byte = {1'b1, sum_q};
      default: cur_byte = ppf_pkg::TermByte;
    endcase
  end

  // Sequencer next state
  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    lo_d   = lo_q;
    sum_d  = sum_q;
    if (adv) begin
      if (slot_q != S_SUM && slot_q != S_TERM) begin
        sum_d = sum_q + cur_byte[6:0];
      end
      if (cur_two) begin
        lo_d = 1'b1;
      end else begin
        lo_d = 1'b0;
        unique case (slot_q)
          S_CMD:    slot_d = S_LEN;
          S_LEN:    slot_d = S_PPL;
          S_PPL:    slot_d = S_LINES;
          S_LINES:  slot_d = S_COMM;
          S_COMM:   slot_d = S_COPIES;
          S_COPIES: slot_d = S_PSM;
          S_PSM:    slot_d = size_on ? S_SIZE : S_MB0;
          S_SIZE:   slot_d = S_MB0;
          S_MB0:    slot_d = S_MB1;
          S_MB1:    slot_d = S_MB2;
          S_MB2:    slot_d = S_MB3;
          S_MB3:    slot_d = S_MB4;
          S_MB4:    slot_d = S_MB5;
          S_MB5:    slot_d = S_MB6;
          S_MB6:    slot_d = S_MB7;
          S_MB7:    slot_d = S_PT_HI;
          S_PT_HI:  slot_d = S_PT_LO;
          S_PT_LO:  slot_d = S_SUM;
          S_SUM:    slot_d = S_TERM;
          S_TERM: begin
            slot_d = S_CMD;
            busy_d = 1'b0;
          end
          default:  slot_d = S_CMD;
        endcase
      end
    end
    if (load) begin
      busy_d = 1'b1;
      slot_d = S_CMD;
      lo_d   = 1'b0;
      sum_d  = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      slot_q    <= S_CMD;
      lo_q      <= 1'b0;
      sum_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
      lo_q   <= lo_d;
      sum_q  <= sum_d;
      if (req_i.valid && req_i.ready) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (frm_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_mode_q    <= '0;
      dot_mode_q     <= '0;
      rect_code_q    <= '0;
      mode_first_q   <= '0;
      mode_second_q  <= '0;
      printer_type_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.reg_index)
        ppf_pkg::REG_LINK_MODE:    link_mode_q    <= cfg_i.wdata[7:0];
        ppf_pkg::REG_DOT_MODE:     dot_mode_q     <= cfg_i.wdata[7:0];
        ppf_pkg::REG_RECT_CODE:    rect_code_q    <= cfg_i.wdata[7:0];
        ppf_pkg::REG_MODE_FIRST:   mode_first_q   <= cfg_i.wdata;
        ppf_pkg::REG_MODE_SECOND:  mode_second_q  <= cfg_i.wdata;
        ppf_pkg::REG_PRINTER_TYPE: printer_type_q <= cfg_i.wdata[15:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      p_ppl_q    <= req_i.pixels_per_line;
      p_lines_q  <= req_i.line_count;
      p_copies_q <= req_i.copy_count;
      p_size_q   <= req_i.size_number;
    end
    if (load) begin
      e_ppl_q    <= p_ppl_q;
      e_lines_q  <= p_lines_q;
      e_copies_q <= p_copies_q;
      e_size_q   <= p_size_q;
      len_q      <= load_len;
    end
    if (adv) begin
      out_byte_q <= cur_byte;
      out_last_q <= (slot_q == S_TERM);
    end
  end

  // Checks
  a_last_is_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_last_q) |-> (out_byte_q == ppf_pkg::TermByte))
    else $error("last byte is not the terminator");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (len_q >= ppf_pkg::BaseLen && len_q <= ppf_pkg::LenW'(22)))
    else $error("frame length out of range");

  a_pend_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !load) |=> pend_q)
    else $error("pending request lost");

endmodule
